>>> hw/rtl/acpr_pkg.sv
`timescale 1ns / 1ps

package acpr_pkg;

    // Width of the character index used for both reply strings and line echo.
    localparam int CIDX_W = 5;

    // Argument of SET_POS and SET_VEL starts right after the eight-character keyword.
    localparam logic [CIDX_W-1:0] ARG_START = 5'd8;

    // Decimal printing walks five powers of ten.
    localparam logic [2:0] LAST_POW = 3'd4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int NUM_KW = 5;

    typedef enum logic [3:0] {
        K_LINE,
        K_OVF,
        K_SETPOS,
        K_SETVEL_OK,
        K_SETVEL_BAD,
        K_GETPOS,
        K_GETVEL,
        K_STATUS,
        K_ERR
    } reply_kind_t;

    typedef enum logic [3:0] {
        STR_CMD,
        STR_CRLF,
        STR_ERR_OVF,
        STR_ERR_VEL,
        STR_OK_POS,
        STR_OK_VEL,
        STR_ERR,
        STR_POS,
        STR_VEL,
        STR_TARGET,
        STR_SPOS,
        STR_SVEL
    } str_id_t;

    typedef enum logic [2:0] {
        KW_SETPOS,
        KW_SETVEL,
        KW_GETPOS,
        KW_GETVEL,
        KW_STATUS
    } kw_id_t;

    typedef enum logic [2:0] {
        OP_STR,
        OP_ECHO,
        OP_NUM,
        OP_DECIDE,
        OP_END
    } plan_op_t;

    typedef enum logic [1:0] {
        NUM_GOAL,
        NUM_POS,
        NUM_SPEED
    } num_sel_t;

    typedef enum logic [1:0] {
        SRC_STR,
        SRC_ECHO,
        SRC_SIGN,
        SRC_DIGIT
    } char_src_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_ITEM,
        CS_STR,
        CS_ECHO,
        CS_NSIGN,
        CS_NDIG
    } ctrl_state_t;

    typedef struct packed {
        plan_op_t op;
        str_id_t  str;
        num_sel_t num;
    } plan_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              start_line;
        logic              clear_ovf;
        logic              clear_line;
        logic              set_goal;
        logic              set_step;
        logic              emit;
        char_src_t         src;
        str_id_t           str;
        logic [CIDX_W-1:0] cidx;
        logic              last;
        logic              scan;
        logic              num_load;
        num_sel_t          num_sel;
        logic              num_sub;
        logic              num_next;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              item_valid;
        logic              item_tick;
        logic              item_eol;
        logic              line_empty;
        logic              ovf;
        logic [CIDX_W-1:0] line_len;
        logic              emit_ok;
        logic              is_setpos;
        logic              is_setvel;
        logic              is_getpos;
        logic              is_getvel;
        logic              is_status;
        logic              arg_neg;
        logic              num_neg;
        logic              num_ge;
        logic              num_show;
        logic              num_last;
    } dp_status_t;

    function automatic logic [CIDX_W-1:0] str_len(str_id_t id);
        case (id)
            STR_CMD:     return 5'd4;
            STR_CRLF:    return 5'd2;
            STR_ERR_OVF: return 5'd16;
            STR_ERR_VEL: return 5'd11;
            STR_OK_POS:  return 5'd12;
            STR_OK_VEL:  return 5'd12;
            STR_ERR:     return 5'd7;
            STR_POS:     return 5'd4;
            STR_VEL:     return 5'd4;
            STR_TARGET:  return 5'd7;
            STR_SPOS:    return 5'd5;
            STR_SVEL:    return 5'd5;
            default:     return 5'd1;
        endcase
    endfunction

    // Character idx of a reply string; strings sit right-justified in a 16-byte word.
    function automatic logic [7:0] str_char(str_id_t id, logic [CIDX_W-1:0] idx);
        logic [127:0] s;
        int           p;
        case (id)
            STR_CMD:     s = 128'("CMD:");
            STR_CRLF:    s = 128'("\015\012");
            STR_ERR_OVF: s = 128'("ERROR OVERFLOW\015\012");
            STR_ERR_VEL: s = 128'("ERROR VEL\015\012");
            STR_OK_POS:  s = 128'("OK SET_POS\015\012");
            STR_OK_VEL:  s = 128'("OK SET_VEL\015\012");
            STR_ERR:     s = 128'("ERROR\015\012");
            STR_POS:     s = 128'("POS:");
            STR_VEL:     s = 128'("VEL:");
            STR_TARGET:  s = 128'("TARGET:");
            STR_SPOS:    s = 128'(" POS:");
            STR_SVEL:    s = 128'(" VEL:");
            default:     s = '0;
        endcase
        p = 8 * (int'(str_len(id)) - 1 - int'(idx));
        if (p < 0)
        begin
            p = 0;
        end
        return s[p +: 8];
    endfunction

    function automatic logic [CIDX_W-1:0] kw_len(kw_id_t k);
        case (k)
            KW_SETPOS: return 5'd8;
            KW_SETVEL: return 5'd8;
            KW_GETPOS: return 5'd7;
            KW_GETVEL: return 5'd7;
            KW_STATUS: return 5'd6;
            default:   return 5'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(kw_id_t k, logic [2:0] idx);
        logic [63:0] s;
        int          p;
        case (k)
            KW_SETPOS: s = 64'("SET_POS ");
            KW_SETVEL: s = 64'("SET_VEL ");
            KW_GETPOS: s = 64'("GET_POS");
            KW_GETVEL: s = 64'("GET_VEL");
            KW_STATUS: s = 64'("STATUS");
            default:   s = '0;
        endcase
        p = 8 * (int'(kw_len(k)) - 1 - int'(idx));
        if (p < 0)
        begin
            p = 0;
        end
        return s[p +: 8];
    endfunction

    function automatic logic [15:0] pow10(logic [2:0] pidx);
        case (pidx)
            3'd0:    return 16'd10000;
            3'd1:    return 16'd1000;
            3'd2:    return 16'd100;
            3'd3:    return 16'd10;
            default: return 16'd1;
        endcase
    endfunction

    function automatic plan_item_t mk_item(plan_op_t op, str_id_t s, num_sel_t n);
        plan_item_t it;
        it.op  = op;
        it.str = s;
        it.num = n;
        return it;
    endfunction

    // Reply program: the sequence of pieces that each reply kind sends.
    function automatic plan_item_t plan(reply_kind_t kind, logic [2:0] idx);
        plan_item_t it;
        it = mk_item(OP_END, STR_CMD, NUM_GOAL);
        case (kind)
            K_LINE:
            begin
                case (idx)
                    3'd0:    it = mk_item(OP_STR, STR_CMD, NUM_GOAL);
                    3'd1:    it = mk_item(OP_ECHO, STR_CMD, NUM_GOAL);
                    3'd2:    it = mk_item(OP_STR, STR_CRLF, NUM_GOAL);
                    3'd3:    it = mk_item(OP_DECIDE, STR_CMD, NUM_GOAL);
                    default: it = mk_item(OP_END, STR_CMD, NUM_GOAL);
                endcase
            end
            K_OVF:
            begin
                if (idx == 3'd0) it = mk_item(OP_STR, STR_ERR_OVF, NUM_GOAL);
            end
            K_SETPOS:
            begin
                if (idx == 3'd0) it = mk_item(OP_STR, STR_OK_POS, NUM_GOAL);
            end
            K_SETVEL_OK:
            begin
                if (idx == 3'd0) it = mk_item(OP_STR, STR_OK_VEL, NUM_GOAL);
            end
            K_SETVEL_BAD:
            begin
                if (idx == 3'd0) it = mk_item(OP_STR, STR_ERR_VEL, NUM_GOAL);
            end
            K_ERR:
            begin
                if (idx == 3'd0) it = mk_item(OP_STR, STR_ERR, NUM_GOAL);
            end
            K_GETPOS:
            begin
                case (idx)
                    3'd0:    it = mk_item(OP_STR, STR_POS, NUM_GOAL);
                    3'd1:    it = mk_item(OP_NUM, STR_CMD, NUM_POS);
                    3'd2:    it = mk_item(OP_STR, STR_CRLF, NUM_GOAL);
                    default: it = mk_item(OP_END, STR_CMD, NUM_GOAL);
                endcase
            end
            K_GETVEL:
            begin
                case (idx)
                    3'd0:    it = mk_item(OP_STR, STR_VEL, NUM_GOAL);
                    3'd1:    it = mk_item(OP_NUM, STR_CMD, NUM_SPEED);
                    3'd2:    it = mk_item(OP_STR, STR_CRLF, NUM_GOAL);
                    default: it = mk_item(OP_END, STR_CMD, NUM_GOAL);
                endcase
            end
            K_STATUS:
            begin
                case (idx)
                    3'd0:    it = mk_item(OP_STR, STR_TARGET, NUM_GOAL);
                    3'd1:    it = mk_item(OP_NUM, STR_CMD, NUM_GOAL);
                    3'd2:    it = mk_item(OP_STR, STR_SPOS, NUM_GOAL);
                    3'd3:    it = mk_item(OP_NUM, STR_CMD, NUM_POS);
                    3'd4:    it = mk_item(OP_STR, STR_SVEL, NUM_GOAL);
                    3'd5:    it = mk_item(OP_NUM, STR_CMD, NUM_SPEED);
                    3'd6:    it = mk_item(OP_STR, STR_CRLF, NUM_GOAL);
                    default: it = mk_item(OP_END, STR_CMD, NUM_GOAL);
                endcase
            end
            default: it = mk_item(OP_END, STR_CMD, NUM_GOAL);
        endcase
        return it;
    endfunction

endpackage

>>> hw/rtl/acpr_item_if.sv
`timescale 1ns / 1ps

// Input channel: received bytes and timer ticks.
interface acpr_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink (input valid, input command, input rx_byte, output ready);
endinterface

>>> hw/rtl/acpr_reply_if.sv
`timescale 1ns / 1ps

// Output channel: reply characters.
interface acpr_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_char;
    logic       last_char;

    modport source (output valid, output tx_char, output last_char, input ready);
    modport sink (input valid, input tx_char, input last_char, output ready);
endinterface

>>> hw/rtl/acpr_ctrl.sv
`timescale 1ns / 1ps

module acpr_ctrl
    import acpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t st,
    output dp_cmd_t    cmd,
    output logic       item_ready
);

    ctrl_state_t       state_reg, state_next;
    reply_kind_t       kind_reg, kind_next;
    logic [2:0]        item_reg, item_next;
    logic [CIDX_W-1:0] cidx_reg, cidx_next;

    plan_item_t cur;
    plan_item_t nxt;
    logic       str_done;
    logic       echo_done;
    logic       line_end;
    logic       num_done;

    // Current and following piece of the reply program.
    assign cur       = plan(kind_reg, item_reg);
    assign nxt       = plan(kind_reg, item_reg + 3'd1);
    assign str_done  = (cidx_reg == str_len(cur.str) - 5'd1);
    assign echo_done = (cidx_reg == st.line_len - 5'd1);
    assign line_end  = st.item_valid && !st.item_tick && st.item_eol && !st.line_empty;
    assign num_done  = !st.num_ge && st.num_last && (!st.num_show || st.emit_ok);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (line_end) state_next = CS_ITEM;
            end
            CS_ITEM:
            begin
                case (cur.op)
                    OP_STR:    state_next = CS_STR;
                    OP_ECHO:   state_next = CS_ECHO;
                    OP_NUM:    state_next = CS_NSIGN;
                    OP_DECIDE: state_next = CS_ITEM;
                    OP_END:    state_next = CS_IDLE;
                    default:   state_next = CS_IDLE;
                endcase
            end
            CS_STR:
            begin
                if (st.emit_ok && str_done) state_next = CS_ITEM;
            end
            CS_ECHO:
            begin
                if (st.emit_ok && echo_done) state_next = CS_ITEM;
            end
            CS_NSIGN:
            begin
                if (!st.num_neg || st.emit_ok) state_next = CS_NDIG;
            end
            CS_NDIG:
            begin
                if (num_done) state_next = CS_ITEM;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // Outputs and sequencing counters.
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        kind_next  = kind_reg;
        item_next  = item_reg;
        cidx_next  = cidx_reg;
        cmd.cidx   = cidx_reg;
        cmd.str    = cur.str;
        cmd.src    = SRC_STR;
        cmd.num_sel = cur.num;
        case (state_reg)
            CS_IDLE:
            begin
                item_ready = 1'b1;
                cmd.accept = st.item_valid;
                if (line_end)
                begin
                    item_next = 3'd0;
                    if (st.ovf)
                    begin
                        cmd.clear_ovf = 1'b1;
                        kind_next     = K_OVF;
                    end
                    else
                    begin
                        cmd.start_line = 1'b1;
                        kind_next      = K_LINE;
                    end
                end
            end
            CS_ITEM:
            begin
                cidx_next = '0;
                if (cur.op == OP_NUM)
                begin
                    cmd.num_load = 1'b1;
                end
                if (cur.op == OP_DECIDE)
                begin
                    cmd.clear_line = 1'b1;
                    item_next      = 3'd0;
                    if (st.is_setpos)
                    begin
                        cmd.set_goal = 1'b1;
                        kind_next    = K_SETPOS;
                    end
                    else if (st.is_setvel)
                    begin
                        if (st.arg_neg)
                        begin
                            kind_next = K_SETVEL_BAD;
                        end
                        else
                        begin
                            cmd.set_step = 1'b1;
                            kind_next    = K_SETVEL_OK;
                        end
                    end
                    else if (st.is_getpos) kind_next = K_GETPOS;
                    else if (st.is_getvel) kind_next = K_GETVEL;
                    else if (st.is_status) kind_next = K_STATUS;
                    else                   kind_next = K_ERR;
                end
            end
            CS_STR:
            begin
                cmd.src  = SRC_STR;
                cmd.emit = st.emit_ok;
                cmd.last = str_done && (nxt.op == OP_END);
                if (st.emit_ok)
                begin
                    if (str_done) item_next = item_reg + 3'd1;
                    else          cidx_next = cidx_reg + 5'd1;
                end
            end
            CS_ECHO:
            begin
                cmd.src  = SRC_ECHO;
                cmd.emit = st.emit_ok;
                cmd.scan = st.emit_ok;
                if (st.emit_ok)
                begin
                    if (echo_done) item_next = item_reg + 3'd1;
                    else           cidx_next = cidx_reg + 5'd1;
                end
            end
            CS_NSIGN:
            begin
                cmd.src  = SRC_SIGN;
                cmd.emit = st.num_neg && st.emit_ok;
            end
            CS_NDIG:
            begin
                cmd.src = SRC_DIGIT;
                if (st.num_ge)
                begin
                    cmd.num_sub = 1'b1;
                end
                else if (!st.num_show)
                begin
                    cmd.num_next = 1'b1;
                end
                else if (st.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.num_next = 1'b1;
                end
                if (num_done) item_next = item_reg + 3'd1;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            kind_reg  <= K_LINE;
            item_reg  <= '0;
            cidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            item_reg  <= item_next;
            cidx_reg  <= cidx_next;
        end
    end

endmodule

>>> hw/rtl/acpr_datapath.sv
`timescale 1ns / 1ps

module acpr_datapath
    import acpr_pkg::*;
#(
    parameter int LINE_DEPTH = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        item_valid,
    input  logic        command,
    input  logic [7:0]  rx_byte,
    input  logic        reply_ready,
    output logic        reply_valid,
    output logic [7:0]  tx_char,
    output logic        last_char,
    input  dp_cmd_t     cmd,
    output dp_status_t  st
);

    localparam int LW = $clog2(LINE_DEPTH);
    localparam logic [LW-1:0] LEN_MAX = LW'(LINE_DEPTH - 1);

    logic [7:0]        line_mem [LINE_DEPTH];
    logic [LW-1:0]     len_reg;
    logic              ovf_reg;
    logic [15:0]       goal_reg, pos_reg, step_reg, speed_reg, tick_reg, tpu_reg;
    logic [NUM_KW-1:0] match_reg;
    logic [15:0]       val_reg;
    logic              neg_reg, act_reg;
    logic [15:0]       mag_reg;
    logic [3:0]        dig_reg;
    logic [2:0]        pidx_reg;
    logic              shown_reg, numneg_reg;
    logic              ovalid_reg, olast_reg;
    logic [7:0]        ochar_reg;

    logic              eol;
    logic              store_byte;
    logic              is_tick;
    logic [7:0]        echo_char;
    logic              echo_digit;
    logic [15:0]       arg;
    logic [15:0]       num_val;
    logic [15:0]       pow;
    logic              emit_ok;
    logic [7:0]        char_next;
    logic [15:0]       tick_next;
    logic              tick_fire;
    logic [15:0]       mpos_next, mspd_next;
    logic signed [17:0] cur_s, goal_s, spd_s, up_s, dn_s;

    assign eol        = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_tick    = cmd.accept && command;
    assign store_byte = cmd.accept && !command && !eol && !ovf_reg;
    assign echo_char  = line_mem[cmd.cidx[LW-1:0]];
    assign echo_digit = (echo_char >= CH_ZERO) && (echo_char <= CH_NINE);
    assign arg        = neg_reg ? (16'd0 - val_reg) : val_reg;
    assign pow        = pow10(pidx_reg);
    assign emit_ok    = !ovalid_reg || reply_ready;

    // Line store writes.
    always_ff @(posedge clk)
    begin
        if (store_byte && (len_reg < LEN_MAX))
        begin
            line_mem[len_reg] <= rx_byte;
        end
    end

    // Line length and overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.clear_ovf)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.clear_line)
        begin
            len_reg <= '0;
        end
        else if (store_byte)
        begin
            if (len_reg < LEN_MAX) len_reg <= len_reg + 1'b1;
            else                   ovf_reg <= 1'b1;
        end
    end

    // Keyword matching and argument parsing as the line is echoed.
    always_ff @(posedge clk)
    begin
        if (cmd.start_line)
        begin
            match_reg <= '1;
            val_reg   <= '0;
            neg_reg   <= 1'b0;
            act_reg   <= 1'b1;
        end
        else if (cmd.scan)
        begin
            for (int k = 0; k < NUM_KW; k++)
            begin
                if ((cmd.cidx < kw_len(kw_id_t'(k)))
                    && (echo_char != kw_char(kw_id_t'(k), cmd.cidx[2:0])))
                begin
                    match_reg[k] <= 1'b0;
                end
            end
            if ((cmd.cidx >= ARG_START) && act_reg)
            begin
                if ((cmd.cidx == ARG_START) && (echo_char == CH_MINUS))
                begin
                    neg_reg <= 1'b1;
                end
                else if (echo_digit)
                begin
                    val_reg <= (val_reg << 3) + (val_reg << 1) + {12'd0, echo_char[3:0]};
                end
                else
                begin
                    act_reg <= 1'b0;
                end
            end
        end
    end

    // Motor step toward the goal, clamped at the goal.
    assign cur_s = 18'(signed'(pos_reg));
    assign goal_s = 18'(signed'(goal_reg));
    assign spd_s = 18'(signed'(step_reg));
    assign up_s  = cur_s + spd_s;
    assign dn_s  = cur_s - spd_s;

    always_comb
    begin
        mpos_next = pos_reg;
        mspd_next = '0;
        if ((cur_s == goal_s) || (step_reg == 16'd0))
        begin
            mpos_next = pos_reg;
        end
        else if (cur_s < goal_s)
        begin
            if (up_s >= goal_s)
            begin
                mpos_next = goal_reg;
            end
            else
            begin
                mpos_next = up_s[15:0];
                mspd_next = step_reg;
            end
        end
        else
        begin
            if (dn_s <= goal_s)
            begin
                mpos_next = goal_reg;
            end
            else
            begin
                mpos_next = dn_s[15:0];
                mspd_next = 16'd0 - step_reg;
            end
        end
    end

    assign tick_next = tick_reg + 16'd1;
    assign tick_fire = (tick_next >= tpu_reg);

    // Motion registers, timer and update period.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg  <= '0;
            pos_reg   <= '0;
            step_reg  <= 16'd1;
            speed_reg <= '0;
            tick_reg  <= '0;
            tpu_reg   <= 16'd50;
        end
        else
        begin
            if (cfg_wr_en) tpu_reg <= cfg_wr_data;
            if (cmd.set_goal) goal_reg <= arg;
            if (cmd.set_step) step_reg <= arg;
            if (is_tick)
            begin
                if (tick_fire)
                begin
                    tick_reg  <= '0;
                    pos_reg   <= mpos_next;
                    speed_reg <= mspd_next;
                end
                else
                begin
                    tick_reg <= tick_next;
                end
            end
        end
    end

    // Decimal conversion by repeated subtraction of powers of ten.
    always_comb
    begin
        case (cmd.num_sel)
            NUM_GOAL:  num_val = goal_reg;
            NUM_POS:   num_val = pos_reg;
            NUM_SPEED: num_val = speed_reg;
            default:   num_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.num_load)
        begin
            numneg_reg <= num_val[15];
            mag_reg    <= num_val[15] ? (16'd0 - num_val) : num_val;
            dig_reg    <= '0;
            pidx_reg   <= '0;
            shown_reg  <= 1'b0;
        end
        else if (cmd.num_sub)
        begin
            mag_reg <= mag_reg - pow;
            dig_reg <= dig_reg + 4'd1;
        end
        else if (cmd.num_next)
        begin
            pidx_reg  <= pidx_reg + 3'd1;
            dig_reg   <= '0;
            shown_reg <= shown_reg || (dig_reg != 4'd0);
        end
    end

    // Reply character selection.
    always_comb
    begin
        case (cmd.src)
            SRC_STR:   char_next = str_char(cmd.str, cmd.cidx);
            SRC_ECHO:  char_next = echo_char;
            SRC_SIGN:  char_next = CH_MINUS;
            SRC_DIGIT: char_next = CH_ZERO + {4'd0, dig_reg};
            default:   char_next = CH_ZERO;
        endcase
    end

    // Output register holds one character until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (reply_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ochar_reg <= char_next;
            olast_reg <= cmd.last;
        end
    end

    assign reply_valid = ovalid_reg;
    assign tx_char     = ochar_reg;
    assign last_char   = olast_reg;

    // Status toward the controller.
    always_comb
    begin
        st            = '0;
        st.item_valid = item_valid;
        st.item_tick  = command;
        st.item_eol   = eol;
        st.line_empty = (len_reg == '0);
        st.ovf        = ovf_reg;
        st.line_len   = CIDX_W'(len_reg);
        st.emit_ok    = emit_ok;
        st.is_setpos  = match_reg[KW_SETPOS] && (st.line_len >= ARG_START);
        st.is_setvel  = match_reg[KW_SETVEL] && (st.line_len >= ARG_START);
        st.is_getpos  = match_reg[KW_GETPOS] && (st.line_len == kw_len(KW_GETPOS));
        st.is_getvel  = match_reg[KW_GETVEL] && (st.line_len == kw_len(KW_GETVEL));
        st.is_status  = match_reg[KW_STATUS] && (st.line_len == kw_len(KW_STATUS));
        st.arg_neg    = arg[15];
        st.num_neg    = numneg_reg;
        st.num_ge     = (mag_reg >= pow);
        st.num_show   = (dig_reg != 4'd0) || shown_reg || (pidx_reg == LAST_POW);
        st.num_last   = (pidx_reg == LAST_POW);
    end

endmodule

>>> hw/rtl/ascii_command_position_ramp_top.sv
`timescale 1ns / 1ps
// ASCII command interpreter with a ramped motor position.
// Channel item (sink): command 0 carries a received byte in rx_byte, command 1 is a
// timer tick. Channel reply (source): one reply character per transfer in tx_char,
// last_char high on the final character of a reply. cfg_wr_en/cfg_wr_data write
// ticks_per_update (reset 50) and are to be used only while the block is idle;
// the block itself does not enforce this. Throughput: a tick or an ordinary byte
// is taken as soon as it is offered, and item.ready stays high so such items may
// arrive every cycle. A CR or LF that ends a non-empty line starts a reply:
// item.ready drops until the whole reply has been handed to the output register.
// Each reply character is handed on as soon as the output register can take it;
// each reply piece also passes through a sequencing state, and each decimal
// number is formed digit by digit by repeated subtraction of powers of ten.
// Stalls: when reply.ready is low, the output register holds its character and the
// sequencer waits; nothing is dropped. Reset clears the line, position, goal and
// speed, sets the step speed to one and the period to 50; no reply is pending.
module ascii_command_position_ramp_top
    import acpr_pkg::*;
#(
    parameter int LINE_DEPTH = 30
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    acpr_item_if.sink     item,
    acpr_reply_if.source  reply
);

    dp_cmd_t    cmd;
    dp_status_t st;
    logic       item_ready;

    assign item.ready = item_ready;

    acpr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .st         (st),
        .cmd        (cmd),
        .item_ready (item_ready)
    );

    acpr_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item.valid),
        .command     (item.command),
        .rx_byte     (item.rx_byte),
        .reply_ready (reply.ready),
        .reply_valid (reply.valid),
        .tx_char     (reply.tx_char),
        .last_char   (reply.last_char),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

>>> hw/rtl/acpr_checker.sv
`timescale 1ns / 1ps

module acpr_checker
    import acpr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       item_command,
    input logic [7:0] item_rx_byte,
    input logic       reply_valid,
    input logic       reply_ready,
    input logic       reply_last_char
);

    // A stalled reply character stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_ready |=> reply_valid)
        else $error("reply character withdrawn while stalled");

    // Ticks and ordinary bytes never start a reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !reply_valid
        && (item_command || ((item_rx_byte != CH_CR) && (item_rx_byte != CH_LF)))
        |=> !reply_valid)
        else $error("reply started without a line end");

    // No new item is taken while a reply is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_last_char |-> !item_ready)
        else $error("input taken in the middle of a reply");

endmodule

bind ascii_command_position_ramp_top acpr_checker u_acpr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_command    (item.command),
    .item_rx_byte    (item.rx_byte),
    .reply_valid     (reply.valid),
    .reply_ready     (reply.ready),
    .reply_last_char (reply.last_char)
);
